[rtl/flow_key_header_parser_defines.svh]
// Assertion macros shared by the flow key header parser.
`ifndef FLOW_KEY_HEADER_PARSER_DEFINES_SVH
`define FLOW_KEY_HEADER_PARSER_DEFINES_SVH
`ifndef SYNTH
`define FKHP_ASSERT_IMP(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("flow key parser check failed");
`define FKHP_ASSERT_NXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("flow key parser check failed");
`else
`define FKHP_ASSERT_IMP(lbl, ck, rn, ante, cons)
`define FKHP_ASSERT_NXT(lbl, ck, rn, ante, cons)
`endif
`endif

[rtl/fkhp_pkg.sv]
// Types, constants and helpers of the flow key header parser.
package fkhp_pkg;

    localparam int unsigned COUNT_LIMIT_DEF = 255;
    localparam int unsigned L3_WIN = 28;
    localparam int unsigned L4_WIN = 4;
    localparam int unsigned QUEUE_DEPTH = 2;

    localparam logic [15:0] ETYPE_MIN  = 16'h0600;
    localparam logic [15:0] ETYPE_8022 = 16'h05ff;
    localparam logic [15:0] ETYPE_VLAN = 16'h8100;
    localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
    localparam logic [15:0] ETYPE_ARP  = 16'h0806;
    localparam logic [7:0]  TOS_MASK   = 8'hfc;
    localparam logic [7:0]  PROTO_ICMP = 8'd1;
    localparam logic [7:0]  PROTO_TCP  = 8'd6;
    localparam logic [7:0]  PROTO_UDP  = 8'd17;
    localparam logic [7:0]  LLC_SAP    = 8'haa;
    localparam logic [7:0]  LLC_UI     = 8'h03;
    localparam logic [7:0]  ARP_PLEN   = 8'd4;

    // Everything the key builder needs from one frame.
    typedef struct packed {
        logic [31:0]                 port;
        logic [7:0]                  n;
        logic [47:0]                 dst;
        logic [47:0]                 src;
        logic [15:0]                 t0;
        logic                        snap_ok;
        logic [15:0]                 t_snap;
        logic [15:0]                 vtci;
        logic [15:0]                 vtype;
        logic [L3_WIN-1:0][7:0]      l3w;
        logic [L4_WIN-1:0][7:0]      l4w;
        logic [7:0]                  l4b12;
    } fkhp_rec_t;

    typedef struct packed {
        logic [31:0] port_out;
        logic [15:0] vlan_id;
        logic [2:0]  vlan_priority;
        logic [47:0] eth_src;
        logic [47:0] eth_dst;
        logic [15:0] frame_type;
        logic [7:0]  ip_tos;
        logic [7:0]  net_proto;
        logic [31:0] ip_src;
        logic [31:0] ip_dst;
        logic [31:0] l4_ports;
        logic        is_fragment;
    } fkhp_key_t;

    typedef struct packed {
        logic empty;
        logic full;
    } fkhp_q_stat_t;

    // Network header start, assuming every tag seen so far is complete.
    function automatic logic [7:0] l3_start(logic [15:0] t0, logic [15:0] t_snap);
        logic        eth2;
        logic [15:0] t1;
        logic [7:0]  off;
        eth2 = (t0 >= ETYPE_MIN);
        t1   = eth2 ? t0 : t_snap;
        off  = eth2 ? 8'd14 : 8'd22;
        return off + ((t1 == ETYPE_VLAN) ? 8'd4 : 8'd0);
    endfunction

endpackage

[rtl/flow_key_header_parser.sv]
// Top level of the flow key header parser: byte stream in, one flow key per frame out.
//
//   Channel   Direction  Word contents
//   s_axis    in         one frame byte and the ingress port, tlast on the final byte
//   m_axis    out        one flow key per frame, tuser flags an IPv4 fragment
//
// The block takes one byte in every cycle while the queue is not full. The front
// end latches each byte into its header field; on the final byte it writes a frame
// record into a two-entry queue, and the back end resolves it into a registered
// key that drives tvalid. Reset clears only counters, queue pointers and the valid
// flag. s_axis_tready drops only while a key waits on a stalled output and two
// more records fill the queue.
`include "flow_key_header_parser_defines.svh"
module flow_key_header_parser #(
    parameter int unsigned COUNT_LIMIT = fkhp_pkg::COUNT_LIMIT_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [39:0]  s_axis_tdata,   // frame_byte [7:0], in_port [39:8]
    input  logic         s_axis_tlast,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [279:0] m_axis_tdata,   // port_out, vlan_id, vlan_priority, eth_src,
                                         // eth_dst, frame_type, ip_tos, net_proto, ip_src,
                                         // ip_dst, l4_ports, zero fill
    output logic         m_axis_tuser    // is_fragment
);

    fkhp_pkg::fkhp_rec_t    front_rec, queue_rec;
    fkhp_pkg::fkhp_q_stat_t q_stat;
    fkhp_pkg::fkhp_key_t    key;
    logic                   push, pop;

    // Front end: byte counting and header field capture.
    fkhp_front #(
        .COUNT_LIMIT(COUNT_LIMIT)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_byte  (s_axis_tdata[7:0]),
        .in_last  (s_axis_tlast),
        .in_port  (s_axis_tdata[39:8]),
        .q_stat   (q_stat),
        .push     (push),
        .rec      (front_rec)
    );

    // Records of finished frames wait here so each side can stall alone.
    fkhp_fifo u_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .wr_rec (front_rec),
        .pop    (pop),
        .rd_rec (queue_rec),
        .q_stat (q_stat)
    );

    // Back end: length checks, field selection and the output register.
    fkhp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (!q_stat.empty),
        .rec       (queue_rec),
        .pop       (pop),
        .key_valid (m_axis_tvalid),
        .key_ready (m_axis_tready),
        .key       (key)
    );

    assign m_axis_tdata = {5'b0, key.l4_ports, key.ip_dst, key.ip_src, key.net_proto,
                           key.ip_tos, key.frame_type, key.eth_dst, key.eth_src,
                           key.vlan_priority, key.vlan_id, key.port_out};
    assign m_axis_tuser = key.is_fragment;

    // A frame that ends is never lost between the queue and the output register.
    `FKHP_ASSERT_NXT(a_key_queued, clk, rst_n, s_axis_tvalid && s_axis_tready && s_axis_tlast, !q_stat.empty || m_axis_tvalid)
    // An idle output register always takes a waiting record.
    `FKHP_ASSERT_NXT(a_queue_drains, clk, rst_n, !q_stat.empty && !m_axis_tvalid, m_axis_tvalid)
    // Fragments never carry transport ports.
    `FKHP_ASSERT_IMP(a_frag_no_ports, clk, rst_n, m_axis_tvalid && m_axis_tuser, m_axis_tdata[274:243] == 32'd0)

endmodule

[rtl/fkhp_front.sv]
// Front end: counts frame bytes and latches header bytes at their offsets.
module fkhp_front #(
    parameter int unsigned COUNT_LIMIT = fkhp_pkg::COUNT_LIMIT_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         in_byte,
    input  logic               in_last,
    input  logic [31:0]        in_port,
    input  fkhp_pkg::fkhp_q_stat_t q_stat,
    output logic               push,
    output fkhp_pkg::fkhp_rec_t rec
);

    localparam int unsigned CW = $clog2(COUNT_LIMIT + 1);
    localparam logic [CW-1:0] CNT_MAX = CW'(COUNT_LIMIT);
    localparam logic [CW-1:0] POS_CAP = CW'(255);

    logic [CW-1:0] cnt_reg, cnt_next, n_full;
    logic [7:0]    pos, n8, off, l3, l4, rel, rel4;
    logic          acc;

    logic [31:0] port_reg, port_next;
    logic [47:0] dst_reg, dst_next, src_reg, src_next;
    logic [15:0] t0_reg, t0_next, tsnap_reg, tsnap_next;
    logic [15:0] vtci_reg, vtci_next, vtype_reg, vtype_next;
    logic        snap_reg, snap_next, llc_match;
    logic [fkhp_pkg::L3_WIN-1:0][7:0] l3w_reg, l3w_next;
    logic [fkhp_pkg::L4_WIN-1:0][7:0] l4w_reg, l4w_next;
    logic [7:0]  l4b12_reg, l4b12_next;

    assign in_ready = !q_stat.full;
    assign acc      = in_valid && in_ready;
    assign push     = acc && in_last;

    assign pos    = (cnt_reg > POS_CAP) ? 8'hff : cnt_reg[7:0];
    assign n_full = (cnt_reg == CNT_MAX) ? cnt_reg : cnt_reg + CW'(1);
    assign n8     = (n_full > POS_CAP) ? 8'hff : n_full[7:0];

    assign off  = (t0_reg >= fkhp_pkg::ETYPE_MIN) ? 8'd14 : 8'd22;
    assign l3   = fkhp_pkg::l3_start(t0_reg, tsnap_reg);
    assign l4   = l3 + {2'b00, l3w_reg[0][3:0], 2'b00};
    assign rel  = pos - l3;
    assign rel4 = pos - l4;

    always_comb
    begin
        unique case (pos)
            8'd14, 8'd15: llc_match = (in_byte == fkhp_pkg::LLC_SAP);
            8'd16:        llc_match = (in_byte == fkhp_pkg::LLC_UI);
            default:      llc_match = (in_byte == 8'h00);
        endcase
    end

    always_comb
    begin
        cnt_next   = cnt_reg;
        port_next  = port_reg;
        dst_next   = dst_reg;
        src_next   = src_reg;
        t0_next    = t0_reg;
        snap_next  = snap_reg;
        tsnap_next = tsnap_reg;
        vtci_next  = vtci_reg;
        vtype_next = vtype_reg;
        l3w_next   = l3w_reg;
        l4w_next   = l4w_reg;
        l4b12_next = l4b12_reg;
        if (acc)
        begin
            if (in_last)
                cnt_next = '0;
            else if (cnt_reg < CNT_MAX)
                cnt_next = cnt_reg + CW'(1);
            if (cnt_reg == '0)
                port_next = in_port;
            if (pos < 8'd6)
                dst_next = {dst_reg[39:0], in_byte};
            else if (pos < 8'd12)
                src_next = {src_reg[39:0], in_byte};
            else if (pos < 8'd14)
                t0_next = {t0_reg[7:0], in_byte};
            else if (pos < 8'd20)
                snap_next = llc_match && ((pos == 8'd14) || snap_reg);
            else if (pos < 8'd22)
                tsnap_next = {tsnap_reg[7:0], in_byte};
            // The tag sits right after the Ethernet or SNAP header.
            if (pos >= off && pos < off + 8'd2)
                vtci_next = {vtci_reg[7:0], in_byte};
            else if (pos >= off + 8'd2 && pos < off + 8'd4)
                vtype_next = {vtype_reg[7:0], in_byte};
            if (pos >= l3 && rel < 8'(fkhp_pkg::L3_WIN))
                l3w_next[rel[4:0]] = in_byte;
            if (pos >= l4 && rel4 < 8'(fkhp_pkg::L4_WIN))
                l4w_next[rel4[1:0]] = in_byte;
            if (pos >= l4 && rel4 == 8'd12)
                l4b12_next = in_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        port_reg  <= port_next;
        dst_reg   <= dst_next;
        src_reg   <= src_next;
        t0_reg    <= t0_next;
        snap_reg  <= snap_next;
        tsnap_reg <= tsnap_next;
        vtci_reg  <= vtci_next;
        vtype_reg <= vtype_next;
        l3w_reg   <= l3w_next;
        l4w_reg   <= l4w_next;
        l4b12_reg <= l4b12_next;
    end

    always_comb
    begin
        rec.port    = port_next;
        rec.n       = n8;
        rec.dst     = dst_next;
        rec.src     = src_next;
        rec.t0      = t0_next;
        rec.snap_ok = snap_next;
        rec.t_snap  = tsnap_next;
        rec.vtci    = vtci_next;
        rec.vtype   = vtype_next;
        rec.l3w     = l3w_next;
        rec.l4w     = l4w_next;
        rec.l4b12   = l4b12_next;
    end

endmodule

[rtl/fkhp_fifo.sv]
// Short queue of finished frame records between front and back end.
module fkhp_fifo (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  fkhp_pkg::fkhp_rec_t     wr_rec,
    input  logic                    pop,
    output fkhp_pkg::fkhp_rec_t     rd_rec,
    output fkhp_pkg::fkhp_q_stat_t  q_stat
);

    localparam int unsigned PW = $clog2(fkhp_pkg::QUEUE_DEPTH);

    fkhp_pkg::fkhp_rec_t mem_reg [fkhp_pkg::QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [PW:0]   count_reg;
    logic          do_push, do_pop;

    assign q_stat.empty = (count_reg == '0);
    assign q_stat.full  = (count_reg == (PW+1)'(fkhp_pkg::QUEUE_DEPTH));
    assign do_push      = push && !q_stat.full;
    assign do_pop       = pop && !q_stat.empty;
    assign rd_rec       = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= wr_rec;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + PW'(1);
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + PW'(1);
            if (do_push && !do_pop)
                count_reg <= count_reg + (PW+1)'(1);
            else if (do_pop && !do_push)
                count_reg <= count_reg - (PW+1)'(1);
        end
    end

endmodule

[rtl/fkhp_back.sv]
// Back end: resolves one frame record into a flow key and holds it for output.
module fkhp_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_valid,
    input  fkhp_pkg::fkhp_rec_t  rec,
    output logic                 pop,
    output logic                 key_valid,
    input  logic                 key_ready,
    output fkhp_pkg::fkhp_key_t  key
);

    fkhp_pkg::fkhp_key_t key_reg, k;
    logic valid_reg;

    assign pop       = q_valid && (!valid_reg || key_ready);
    assign key_valid = valid_reg;
    assign key       = key_reg;

    always_comb
    begin
        logic [7:0]  n, off, ihl, l4, tl;
        logic [15:0] typ;
        logic        keep;
        n    = rec.n;
        off  = 8'd14;
        ihl  = {2'b00, rec.l3w[0][3:0], 2'b00};
        l4   = 8'd0;
        tl   = {2'b00, rec.l4b12[7:4], 2'b00};
        typ  = 16'd0;
        keep = 1'b0;
        k    = '0;
        k.port_out = rec.port;
        k.vlan_id  = 16'hffff;
        if (n >= 8'd14)
        begin
            typ  = rec.t0;
            keep = 1'b1;
            if (rec.t0 < fkhp_pkg::ETYPE_MIN)
            begin
                priority if (n < 8'd17)
                    keep = 1'b0;
                else if (n >= 8'd22 && rec.snap_ok)
                begin
                    typ = rec.t_snap;
                    off = 8'd22;
                end
                else
                begin
                    typ = fkhp_pkg::ETYPE_8022;
                    off = 8'd17;
                end
            end
            if (keep)
            begin
                if (typ == fkhp_pkg::ETYPE_VLAN && n >= off + 8'd4)
                begin
                    k.vlan_id       = {4'h0, rec.vtci[11:0]};
                    k.vlan_priority = rec.vtci[15:13];
                    typ             = rec.vtype;
                    off             = off + 8'd4;
                end
                k.eth_src = rec.src;
                k.eth_dst = rec.dst;
                l4 = off + ihl;
                if (typ == fkhp_pkg::ETYPE_IPV4)
                begin
                    if (n >= off + 8'd20 && ihl >= 8'd20 && n >= l4)
                    begin
                        k.ip_tos    = rec.l3w[1] & fkhp_pkg::TOS_MASK;
                        k.net_proto = rec.l3w[9];
                        k.ip_src    = {rec.l3w[12], rec.l3w[13], rec.l3w[14], rec.l3w[15]};
                        k.ip_dst    = {rec.l3w[16], rec.l3w[17], rec.l3w[18], rec.l3w[19]};
                        if ({rec.l3w[6][5:0], rec.l3w[7]} != 14'd0)
                            k.is_fragment = 1'b1;
                        else if (k.net_proto == fkhp_pkg::PROTO_TCP)
                        begin
                            if (n >= l4 + 8'd20 && tl >= 8'd20 && n >= l4 + tl)
                                k.l4_ports = {rec.l4w[0], rec.l4w[1], rec.l4w[2], rec.l4w[3]};
                            else
                                k.net_proto = 8'd0;
                        end
                        else if (k.net_proto == fkhp_pkg::PROTO_UDP)
                        begin
                            if (n >= l4 + 8'd8)
                                k.l4_ports = {rec.l4w[0], rec.l4w[1], rec.l4w[2], rec.l4w[3]};
                            else
                                k.net_proto = 8'd0;
                        end
                        else if (k.net_proto == fkhp_pkg::PROTO_ICMP)
                        begin
                            if (n >= l4 + 8'd4)
                                k.l4_ports = {8'd0, rec.l4w[0], 8'd0, rec.l4w[1]};
                            else
                                k.net_proto = 8'd0;
                        end
                    end
                end
                else if (typ == fkhp_pkg::ETYPE_ARP && n >= off + 8'd28)
                begin
                    if ({rec.l3w[2], rec.l3w[3]} == fkhp_pkg::ETYPE_IPV4 &&
                        rec.l3w[5] == fkhp_pkg::ARP_PLEN)
                    begin
                        k.ip_src = {rec.l3w[14], rec.l3w[15], rec.l3w[16], rec.l3w[17]};
                        k.ip_dst = {rec.l3w[24], rec.l3w[25], rec.l3w[26], rec.l3w[27]};
                    end
                    k.net_proto = rec.l3w[7];
                end
            end
            else
                typ = 16'd0;
        end
        k.frame_type = typ;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (pop)
            valid_reg <= 1'b1;
        else if (key_ready)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            key_reg <= k;
    end

endmodule
